### hw/rtl/riff_cartridge_image_parser_macros.svh
// Assertion macros for the RIFF cartridge image parser.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef RIFF_CARTRIDGE_IMAGE_PARSER_MACROS_SVH
`define RIFF_CARTRIDGE_IMAGE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RCIP_ASSERT_NOW(label, cond_a, cond_c) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_c)) \
      else $error("rcip assertion failed");
// Next-cycle implication.
`define RCIP_ASSERT_NEXT(label, cond_a, cond_c) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_c)) \
      else $error("rcip assertion failed");
`else
`define RCIP_ASSERT_NOW(label, cond_a, cond_c)
`define RCIP_ASSERT_NEXT(label, cond_a, cond_c)
`endif
`endif

### hw/rtl/rcip_pkg.sv
// Package for the RIFF cartridge image parser: types, magic constants, sizes.
// No dependencies; used by every module of the block.
package rcip_pkg;

   // Bank geometry of the cartridge ROM.
   localparam int BANK_BYTES = 16384;
   localparam int WOFF_W = $clog2(BANK_BYTES) + 1;

   // Smallest image that can hold the two magic fields.
   localparam logic [23:0] MIN_IMAGE = 24'd12;

   // Header magic strings, byte by byte in stream order.
   localparam logic [7:0] RIFF_MAGIC [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
   localparam logic [7:0] AMS_MAGIC [4] = '{8'h41, 8'h4D, 8'h53, 8'h21};
   localparam logic [31:0] FMT_TAG = 32'h666D7420;
   localparam logic [7:0] TAG_C = 8'h63;
   localparam logic [7:0] TAG_B = 8'h62;
   localparam logic [7:0] ASCII_ZERO = 8'h30;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_MAGIC,
      PH_FMTCHK,
      PH_FMTSKIP,
      PH_TAG,
      PH_SIZE,
      PH_DATA
   } rcip_phase_type;

   typedef enum logic [2:0] {
      EV_EJECT = 3'd0,
      EV_CLEAR = 3'd1,
      EV_WRITE = 3'd2,
      EV_DONE  = 3'd3,
      EV_FAIL  = 3'd4
   } rcip_event_type;

   typedef struct packed {
      rcip_event_type kind;
      logic [7:0]     bank;
      logic [13:0]    offset;
      logic [7:0]     wdata;
      logic           last;
   } rcip_result_type;

endpackage

### hw/rtl/rcip_result_queue.sv
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on rcip_pkg for the result struct.
module rcip_result_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               push_n,
   input  rcip_pkg::rcip_result_type push_a,
   input  rcip_pkg::rcip_result_type push_b,
   output logic                     space_ok,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rcip_pkg::rcip_result_type out_data
);
   import rcip_pkg::*;

   rcip_result_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   // Room for a two-result request is required before a request is taken.
   assign space_ok  = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_n} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; the second result goes to the slot after the first.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_a;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push_b;
      end
   end

endmodule

### hw/rtl/riff_cartridge_image_parser.sv
// RIFF cartridge image parser: top level with the byte parser and state.
// Depends on rcip_pkg, rcip_result_queue and the assertion macro header.
//
// Usage: write the image length on the csr channel (csr_valid/csr_image_size,
// always ready), then stream the image one byte per request on the req
// channel, with req_first_byte high on byte 0. Each request gives zero, one
// or two results on the rsp channel (eject, bank clear, byte write, finished,
// failed); rsp_last_of_run marks the final result of a request.
// A result is registered in the result queue before it appears on rsp.
// Throughput: one request per cycle while results are drained as fast as they
// come; a request that gives two results hands them out on rsp one after the
// other. The four-entry result queue sets this: req_ready is high while at
// least two entries are free.
// Reset clears the parser to the stopped state: bytes without req_first_byte
// give no results until the next first byte. When the receiver stalls, the
// queue fills and req_ready drops; nothing is lost.
`include "riff_cartridge_image_parser_macros.svh"

module riff_cartridge_image_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_image_size,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_bank,
   output logic [13:0] rsp_offset,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_last_of_run
);
   import rcip_pkg::*;

   logic [23:0]       image_size_ff;
   logic [23:0]       position_ff, position_in;
   rcip_phase_type    phase_ff, phase_in;
   logic [31:0]       window_ff, window_in;
   logic [7:0]        bank_ff, bank_in;
   logic [23:0]       left_ff, left_in;
   logic [WOFF_W-1:0] woff_ff, woff_in;
   logic              stopped_ff, stopped_in;
   logic [1:0]        hcount_ff, hcount_in;

   logic              req_fire;
   logic              space_ok;
   logic [1:0]        push_n;
   rcip_result_type   res_c [2];
   rcip_result_type   head;

   logic [31:0]       tag_win, size_win;
   logic signed [12:0] dig0, dig1, tag_bank;
   logic              tag_good;
   logic [23:0]       pos;
   logic [24:0]       next_pos;
   logic              run;
   logic              do_bnd;
   rcip_phase_type    bnd_phase;

   assign csr_ready = 1'b1;
   assign req_ready = space_ok;
   assign req_fire  = req_valid && req_ready;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         image_size_ff <= csr_image_size;
      end
   end

   // Shifted header windows and the bank number decoded from a chunk tag.
   always_comb begin
      tag_win  = {window_ff[23:0], req_data_byte};
      size_win = {req_data_byte, window_ff[31:8]};
      dig0     = $signed({5'b0, tag_win[15:8]}) - $signed({5'b0, ASCII_ZERO});
      dig1     = $signed({5'b0, tag_win[7:0]}) - $signed({5'b0, ASCII_ZERO});
      tag_bank = (dig0 <<< 3) + (dig0 <<< 1) + dig1;
      tag_good = (tag_win[31:24] == TAG_C) && (tag_win[23:16] == TAG_B)
                 && (tag_bank[12:8] == 5'd0);
   end

   // Parser: next state and the results of the accepted request.
   always_comb begin
      position_in = position_ff;
      phase_in    = phase_ff;
      window_in   = window_ff;
      bank_in     = bank_ff;
      left_in     = left_ff;
      woff_in     = woff_ff;
      stopped_in  = stopped_ff;
      hcount_in   = hcount_ff;
      push_n      = 2'd0;
      res_c[0]    = '{kind: EV_EJECT, default: '0};
      res_c[1]    = '{kind: EV_EJECT, default: '0};
      run         = 1'b0;
      do_bnd      = 1'b0;
      bnd_phase   = PH_TAG;
      pos         = req_first_byte ? 24'd0 : position_ff;
      next_pos    = {1'b0, pos} + 25'd1;

      if (req_fire) begin
         // A first byte restarts the parse from any state.
         if (req_first_byte) begin
            window_in  = '0;
            bank_in    = '0;
            left_in    = '0;
            woff_in    = '0;
            hcount_in  = '0;
            stopped_in = 1'b0;
            phase_in   = PH_MAGIC;
            if (image_size_ff < MIN_IMAGE) begin
               res_c[0]   = '{kind: EV_FAIL, default: '0};
               push_n     = 2'd1;
               stopped_in = 1'b1;
               phase_in   = PH_IDLE;
            end else begin
               run = 1'b1;
            end
         end else begin
            run = !stopped_ff;
         end
      end

      if (run) begin
         position_in = next_pos[23:0];
         case (phase_in)
            PH_MAGIC: begin
               if ((pos < 24'd4) && (req_data_byte != RIFF_MAGIC[pos[1:0]])) begin
                  res_c[0]   = '{kind: EV_FAIL, default: '0};
                  push_n     = 2'd1;
                  stopped_in = 1'b1;
                  phase_in   = PH_IDLE;
               end else if ((pos[23:2] == 22'd2)
                            && (req_data_byte != AMS_MAGIC[pos[1:0]])) begin
                  res_c[0]   = '{kind: EV_FAIL, default: '0};
                  push_n     = 2'd1;
                  stopped_in = 1'b1;
                  phase_in   = PH_IDLE;
               end else if (pos == 24'd11) begin
                  res_c[0]  = '{kind: EV_EJECT, default: '0};
                  push_n    = 2'd1;
                  do_bnd    = 1'b1;
                  bnd_phase = PH_FMTCHK;
               end
            end
            PH_FMTCHK, PH_TAG: begin
               window_in = tag_win;
               hcount_in = hcount_ff + 2'd1;
               if (hcount_ff == 2'd3) begin
                  hcount_in = 2'd0;
                  if ((phase_in == PH_FMTCHK) && (tag_win == FMT_TAG)) begin
                     phase_in = PH_FMTSKIP;
                  end else if (tag_good) begin
                     bank_in   = tag_bank[7:0];
                     phase_in  = PH_SIZE;
                     window_in = '0;
                  end else begin
                     res_c[0]   = '{kind: EV_FAIL, default: '0};
                     push_n     = 2'd1;
                     stopped_in = 1'b1;
                     phase_in   = PH_IDLE;
                  end
               end
            end
            PH_FMTSKIP: begin
               hcount_in = hcount_ff + 2'd1;
               if (hcount_ff == 2'd3) begin
                  do_bnd = 1'b1;
               end
            end
            PH_SIZE: begin
               window_in = size_win;
               hcount_in = hcount_ff + 2'd1;
               if (hcount_ff == 2'd3) begin
                  hcount_in = 2'd0;
                  if (size_win > {8'd0, image_size_ff}) begin
                     res_c[0]   = '{kind: EV_FAIL, default: '0};
                     push_n     = 2'd1;
                     stopped_in = 1'b1;
                     phase_in   = PH_IDLE;
                  end else begin
                     res_c[0] = '{kind: EV_CLEAR, bank: bank_ff, default: '0};
                     push_n   = 2'd1;
                     left_in  = size_win[23:0];
                     woff_in  = '0;
                     if (size_win == 32'd0) begin
                        do_bnd = 1'b1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
            end
            PH_DATA: begin
               // Bytes past the end of the bank are dropped silently.
               if (woff_ff < WOFF_W'(BANK_BYTES)) begin
                  res_c[0] = '{kind: EV_WRITE, bank: bank_ff, offset: 14'(woff_ff),
                               wdata: req_data_byte, last: 1'b0};
                  push_n   = 2'd1;
                  woff_in  = woff_ff + WOFF_W'(1);
               end
               left_in = left_ff - 24'd1;
               if (left_ff == 24'd1) begin
                  do_bnd = 1'b1;
               end else if (next_pos >= {1'b0, image_size_ff}) begin
                  res_c[push_n[0]] = '{kind: EV_DONE, default: '0};
                  push_n           = push_n + 2'd1;
                  stopped_in       = 1'b1;
                  phase_in         = PH_IDLE;
               end
            end
            default: begin
               stopped_in = 1'b1;
               phase_in   = PH_IDLE;
            end
         endcase

         // Chunk boundary: go on to the next header or finish.
         if (do_bnd) begin
            if (({1'b0, next_pos} + 26'd8) < {2'b00, image_size_ff}) begin
               phase_in  = bnd_phase;
               hcount_in = 2'd0;
               window_in = '0;
            end else begin
               res_c[push_n[0]] = '{kind: EV_DONE, default: '0};
               push_n           = push_n + 2'd1;
               stopped_in       = 1'b1;
               phase_in         = PH_IDLE;
            end
         end
      end

      // Mark the final result of this request.
      if (push_n != 2'd0) begin
         res_c[1'(push_n - 2'd1)].last = 1'b1;
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         phase_ff    <= PH_IDLE;
         window_ff   <= '0;
         bank_ff     <= '0;
         left_ff     <= '0;
         woff_ff     <= '0;
         stopped_ff  <= 1'b1;
         hcount_ff   <= '0;
      end else begin
         position_ff <= position_in;
         phase_ff    <= phase_in;
         window_ff   <= window_in;
         bank_ff     <= bank_in;
         left_ff     <= left_in;
         woff_ff     <= woff_in;
         stopped_ff  <= stopped_in;
         hcount_ff   <= hcount_in;
      end
   end

   // Result queue toward the rsp channel.
   rcip_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_a    (res_c[0]),
      .push_b    (res_c[1]),
      .space_ok  (space_ok),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_event_kind  = head.kind;
   assign rsp_bank        = head.bank;
   assign rsp_offset      = head.offset;
   assign rsp_write_data  = head.wdata;
   assign rsp_last_of_run = head.last;

   // A restart with a short image always reports a failure at once.
   `RCIP_ASSERT_NEXT(a_short_fail, req_fire && req_first_byte && (image_size_ff < MIN_IMAGE), rsp_valid)
   // A stopped parser ignores bytes that do not restart it.
   `RCIP_ASSERT_NOW(a_stopped_quiet, req_fire && stopped_ff && !req_first_byte, push_n == 2'd0)
   // With two results, only the second carries the end-of-request mark.
   `RCIP_ASSERT_NOW(a_last_mark, push_n == 2'd2, res_c[1].last && !res_c[0].last)
   // Nothing is produced without an accepted request.
   `RCIP_ASSERT_NOW(a_no_idle_push, !req_fire, push_n == 2'd0)

endmodule
